FILE: sv/izr_pkg.sv
`default_nettype none

package izr_pkg;

  localparam int NumGroups = 8;
  localparam int GroupBits = 16;
  localparam int GrpIdxW   = 3;
  localparam int CharW     = 7;

  localparam logic [GrpIdxW-1:0] LastGrp = GrpIdxW'(NumGroups - 1);

  // ASCII codes; CharAlpha is 'a' less ten, so 'a'..'f' come from adding the nibble.
  localparam logic [CharW-1:0] CharColon = 7'h3a;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharAlpha = 7'h57;

  typedef struct packed {
    logic [GroupBits-1:0] group_0;
    logic [GroupBits-1:0] group_1;
    logic [GroupBits-1:0] group_2;
    logic [GroupBits-1:0] group_3;
    logic [GroupBits-1:0] group_4;
    logic [GroupBits-1:0] group_5;
    logic [GroupBits-1:0] group_6;
    logic [GroupBits-1:0] group_7;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } out_item_t;

  // Everything the character sequencer needs for one address.
  typedef struct packed {
    logic [NumGroups-1:0][GroupBits-1:0] grp;
    logic                                compress;
    logic [GrpIdxW-1:0]                  startp;
    logic [GrpIdxW-1:0]                  endp;
  } plan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLON,
    ST_DIGIT,
    ST_DCOLON1,
    ST_DCOLON2
  } ser_state_t;

endpackage

`default_nettype wire

FILE: sv/izr_plan.sv
`default_nettype none

// Pick the zero run to compress for one address.
module izr_plan
  import izr_pkg::*;
(
  input  wire in_item_t item,
  output plan_t         plan
);

  localparam int RunW = $clog2(NumGroups + 1);

  logic [NumGroups-1:0][GroupBits-1:0] g;
  logic [RunW-1:0]                     run [NumGroups];
  logic [RunW-1:0]                     len;
  logic [GrpIdxW-1:0]                  endp;
  logic                                found;
  logic                                tie_at_front;

  assign g[0] = item.group_0;
  assign g[1] = item.group_1;
  assign g[2] = item.group_2;
  assign g[3] = item.group_3;
  assign g[4] = item.group_4;
  assign g[5] = item.group_5;
  assign g[6] = item.group_6;
  assign g[7] = item.group_7;

  always_comb begin
    len   = '0;
    found = 1'b0;
    endp  = '0;
    for (int i = 0; i < NumGroups; i++) begin
      if (g[i] == '0) begin
        run[i] = ((i > 0) ? run[(i > 0) ? i - 1 : 0] : '0) + RunW'(1);
      end else begin
        run[i] = '0;
      end
      if (run[i] > len) begin
        len = run[i];
      end
    end
    // Ascending scan: the last hit is the rightmost run ending before the last group.
    for (int i = 0; i < NumGroups - 1; i++) begin
      if (run[i] == len) begin
        found = 1'b1;
        endp  = GrpIdxW'(i);
      end
    end
    tie_at_front = ({1'b0, endp} + RunW'(1)) == len;
    if ((!found || tie_at_front) && run[NumGroups-1] == len) begin
      endp = LastGrp;
    end
  end

  assign plan.grp      = g;
  assign plan.compress = len > RunW'(1);
  assign plan.endp     = endp;
  assign plan.startp   = GrpIdxW'({1'b0, endp} - len + RunW'(1));

endmodule

`default_nettype wire

FILE: sv/ipv6_zero_run_text_compressor.sv
`default_nettype none

// Prints one IPv6 address, taken as eight 16-bit groups, as text with one ASCII
// character per output transfer: lowercase hex groups without leading zeros,
// colon separated, with the longest run of two or more zero groups folded into
// "::" and last_char marking the final character. An address prints as 2 to 39
// characters, and the sequencer emits one character per cycle into the output
// register while the sink keeps taking them; the next address is planned
// from the input register in the very cycle the previous last character goes
// out, so back-to-back addresses stream without a gap. The input register takes
// a new address as soon as the held one moves on to the sequencer. A stalled
// sink holds the character in the output register, and with it the sequencer
// and the hand-over of the held address, until that character is taken.
module ipv6_zero_run_text_compressor
  import izr_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output out_item_t      out_data
);

  // Index of the first nibble to print: leading zero nibbles are dropped,
  // the lowest nibble always prints.
  function automatic logic [1:0] lead_nib(input logic [GroupBits-1:0] v);
    logic [1:0] r;
    priority if (v[15:12] != '0) r = 2'd0;
    else if (v[11:8] != '0)      r = 2'd1;
    else if (v[7:4] != '0)       r = 2'd2;
    else                         r = 2'd3;
    return r;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? CharZero + CharW'(d) : CharAlpha + CharW'(d);
  endfunction

  // Input register
  logic     in_valid_r, in_valid_nxt;
  in_item_t in_data_r;

  // Sequencer
  ser_state_t         state_r, state_nxt;
  plan_t              plan_r, plan_nxt;
  plan_t              plan_w;
  logic [GrpIdxW-1:0] grp_r, grp_nxt;
  logic [1:0]         nib_r, nib_nxt;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic                 advance;
  logic                 done;
  logic                 load;
  logic                 last;
  logic [CharW-1:0]     chr;
  logic [GroupBits-1:0] cur_grp;
  logic [3:0]           cur_nib;
  logic [GrpIdxW-1:0]   grp_inc;
  logic [GrpIdxW-1:0]   endp_inc;

  izr_plan u_plan (
    .item (in_data_r),
    .plan (plan_w)
  );

  // Emit a character whenever the output register is free or being drained.
  assign advance  = (state_r != ST_IDLE) && (!out_valid_r || out_ready);
  assign done     = (state_r == ST_IDLE) || (advance && last);
  assign load     = done && in_valid_r;
  assign in_ready = !in_valid_r || load;

  assign cur_grp  = plan_r.grp[grp_r];
  assign grp_inc  = grp_r + GrpIdxW'(1);
  assign endp_inc = plan_r.endp + GrpIdxW'(1);

  always_comb begin
    unique case (nib_r)
      2'd0:    cur_nib = cur_grp[15:12];
      2'd1:    cur_nib = cur_grp[11:8];
      2'd2:    cur_nib = cur_grp[7:4];
      default: cur_nib = cur_grp[3:0];
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    plan_nxt     = plan_r;
    grp_nxt      = grp_r;
    nib_nxt      = nib_r;
    chr          = CharColon;
    last         = 1'b0;
    in_valid_nxt = in_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        // wait for an address in the input register
      end
      ST_COLON: begin
        if (advance) begin
          state_nxt = ST_DIGIT;
          nib_nxt   = lead_nib(cur_grp);
        end
      end
      ST_DIGIT: begin
        chr  = hex_char(cur_nib);
        last = (nib_r == 2'd3) && (grp_r == LastGrp);
        if (advance && nib_r != 2'd3) begin
          nib_nxt = nib_r + 2'd1;
        end else if (advance && !last) begin
          // next group: either the start of the folded run or a colon first
          grp_nxt = grp_inc;
          if (plan_r.compress && grp_inc == plan_r.startp) begin
            state_nxt = ST_DCOLON1;
          end else begin
            state_nxt = ST_COLON;
          end
        end
      end
      ST_DCOLON1: begin
        if (advance) begin
          state_nxt = ST_DCOLON2;
        end
      end
      ST_DCOLON2: begin
        last = plan_r.endp == LastGrp;
        if (advance && !last) begin
          // resume after the run with no separating colon
          grp_nxt   = endp_inc;
          state_nxt = ST_DIGIT;
          nib_nxt   = lead_nib(plan_r.grp[endp_inc]);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Hand the held address to the sequencer, or drop back to idle.
    if (done) begin
      if (in_valid_r) begin
        plan_nxt     = plan_w;
        grp_nxt      = '0;
        in_valid_nxt = 1'b0;
        if (plan_w.compress && plan_w.startp == '0) begin
          state_nxt = ST_DCOLON1;
        end else begin
          state_nxt = ST_DIGIT;
          nib_nxt   = lead_nib(plan_w.grp[0]);
        end
      end else begin
        state_nxt = ST_IDLE;
      end
    end

    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
    grp_r  <= grp_nxt;
    nib_r  <= nib_nxt;
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.char_code <= chr;
      out_data_r.last_char <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A separator colon never precedes the first group.
  a_colon_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COLON |-> grp_r != '0)
    else $error("separator colon scheduled before the first group");

  // The double colon is only printed for a folded run.
  a_dcolon_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DCOLON1 || state_r == ST_DCOLON2) |-> plan_r.compress)
    else $error("double colon without a compressed run");

  // Digits are never printed for a group inside the folded run.
  a_no_digit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && plan_r.compress) |->
      (grp_r < plan_r.startp || grp_r > plan_r.endp))
    else $error("digit emitted for a group inside the folded run");

  // A held address is picked up as soon as the sequencer is idle.
  a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid_r) |=> state_r != ST_IDLE)
    else $error("held address not taken by the idle sequencer");

  // After the final character with nothing waiting, the sequencer goes idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last && !in_valid_r) |=> state_r == ST_IDLE)
    else $error("sequencer kept running after the final character");

endmodule

`default_nettype wire
